[design/arp_pkg.sv]
package arp_pkg;

	localparam int unsigned WINDOW_LEN = 7;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	localparam logic [6:0] LOSS_LIMIT_RESET = 7'd5;

	localparam logic [2:0] COUNT_SHORT = 3'd6;
	localparam logic [2:0] COUNT_LONG  = 3'd7;

	localparam logic [15:0] WEIGHT_THOUSANDS = 16'd1000;
	localparam logic [15:0] WEIGHT_HUNDREDS  = 16'd100;
	localparam logic [15:0] WEIGHT_TENS      = 16'd10;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] digit_t;

	// what the decode stage needs from one accepted item
	typedef struct packed {
		logic   frame_done;
		logic   long_frame;
		logic   working;
		digit_t d0;
		digit_t d1;
		digit_t d3;
		digit_t d4;
	} stage1_t;

endpackage

[design/arp_window_cell.sv]
module arp_window_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  arp_pkg::byte_t byte_in,
	output arp_pkg::byte_t byte_out,
	output arp_pkg::digit_t digit_out
);
	import arp_pkg::*;

	byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	// ascii digit value, unchecked, wraps to 16 bits
	assign digit_out = {8'h00, byte_q} - {8'h00, CHAR_ZERO};

endmodule

[design/arp_health.sv]
module arp_health (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       loss_limit_we,
	input  logic [6:0] loss_limit_wdata,
	input  logic       tick,
	input  logic       frame,
	output logic       working_next
);
	import arp_pkg::*;

	logic [6:0] limit_q;
	logic [6:0] missed_q;
	logic       frame_seen_q;
	logic       working_q;
	logic       at_limit;

	assign at_limit = (missed_q >= limit_q);

	always_comb begin
		working_next = working_q;
		if (tick) begin
			if (frame_seen_q) begin
				working_next = 1'b1;
			end else if (at_limit) begin
				working_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= LOSS_LIMIT_RESET;
			missed_q     <= '0;
			frame_seen_q <= 1'b0;
			working_q    <= 1'b0;
		end else begin
			if (loss_limit_we) begin
				limit_q <= loss_limit_wdata;
			end
			working_q <= working_next;
			if (tick) begin
				if (frame_seen_q) begin
					frame_seen_q <= 1'b0;
					missed_q     <= '0;
				end else if (!at_limit) begin
					missed_q <= missed_q + 7'd1;
				end
			end else if (frame) begin
				frame_seen_q <= 1'b1;
			end
		end
	end

endmodule

[design/arp_decode.sv]
module arp_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  arp_pkg::stage1_t s1,
	output logic [15:0]      distance_cm,
	output logic             new_distance,
	output logic             sensor_working
);
	import arp_pkg::*;

	digit_t short_sum;
	digit_t full_sum;
	digit_t dist_s2;
	logic   new_s2;
	logic   working_s2;

	assign short_sum = s1.d1 * WEIGHT_HUNDREDS + s1.d3 * WEIGHT_TENS + s1.d4;
	assign full_sum  = s1.long_frame ? short_sum + s1.d0 * WEIGHT_THOUSANDS : short_sum;

	// dist_s2 only moves on a frame, so it is also the last decoded distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_s2    <= '0;
			new_s2     <= 1'b0;
			working_s2 <= 1'b0;
		end else if (load) begin
			if (s1.frame_done) begin
				dist_s2 <= full_sum;
			end
			new_s2     <= s1.frame_done;
			working_s2 <= s1.working;
		end
	end

	assign distance_cm    = dist_s2;
	assign new_distance   = new_s2;
	assign sensor_working = working_s2;

endmodule

[design/ascii_range_packet_parser_core.sv]
// ascii rangefinder frame parser: takes serial bytes (tuser low) and health check
// ticks (tuser high) and returns one item per input item with the last decoded
// distance in cm, a flag for a frame completed by this byte, and the sensor
// working flag. frames are "D.DD\r\n" or "DD.DD\r\n", digits unchecked, distance
// wraps to 16 bits. a new item is taken every cycle unless both stages are full
// and m_axis_tready is low; each result passes the stage-1 capture register and
// then the decode/output register. loss_limit is written through a plain write
// enable and should only change while no item is in flight.
module ascii_range_packet_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        loss_limit_we,
	input  logic [6:0]  loss_limit_wdata,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tuser,   // [0] action: 0 byte, 1 check tick
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [15:0] distance_cm, [16] new_distance,
	                                    // [17] sensor_working, [23:18] zero
);
	import arp_pkg::*;

	logic    accept;
	logic    byte_take;
	logic    tick_take;
	logic    s1_valid_q;
	logic    s2_valid_q;
	logic    s2_load;
	stage1_t s1_s1;
	stage1_t s1_next;

	logic [2:0] count_q;
	logic [2:0] count_inc;
	logic       crlf;
	logic       frame_done;
	logic       working_next;

	byte_t  win_byte  [WINDOW_LEN];
	byte_t  win_in    [WINDOW_LEN];
	digit_t win_digit [WINDOW_LEN];
	byte_t  next_byte [WINDOW_LEN];

	logic [15:0] distance_cm;
	logic        new_distance;
	logic        sensor_working;

	// two-deep flow: stage 1 holds the captured item, stage 2 the output
	assign s2_load       = s1_valid_q && (!s2_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s2_load;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign byte_take     = accept && !s_axis_tuser;
	assign tick_take     = accept && s_axis_tuser;

	// row of window cells, newest byte enters at the top end
	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_win
			if (gi == WINDOW_LEN - 1) begin : g_head
				assign win_in[gi] = s_axis_tdata;
			end else begin : g_link
				assign win_in[gi] = win_byte[gi + 1];
			end
			arp_window_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift_en  (byte_take),
				.byte_in   (win_in[gi]),
				.byte_out  (win_byte[gi]),
				.digit_out (win_digit[gi])
			);
			// window contents as they are after the incoming byte shifts in
			assign next_byte[gi] = win_in[gi];
		end
	endgenerate

	// frame end check on the window as it will be after this byte
	assign count_inc  = count_q + 3'd1;
	assign crlf       = (next_byte[6] == CHAR_LF) && (next_byte[5] == CHAR_CR);
	assign frame_done = crlf && ((count_inc == COUNT_SHORT) || (count_inc == COUNT_LONG));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (byte_take) begin
			if (crlf || (count_inc == COUNT_LONG)) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc;
			end
		end
	end

	arp_health u_health (
		.clk              (clk),
		.arst_n           (arst_n),
		.loss_limit_we    (loss_limit_we),
		.loss_limit_wdata (loss_limit_wdata),
		.tick             (tick_take),
		.frame            (byte_take && frame_done),
		.working_next     (working_next)
	);

	// digits of the shifted window, i.e. the neighbor's current digit
	always_comb begin
		s1_next.frame_done = byte_take && frame_done;
		s1_next.long_frame = (count_inc == COUNT_LONG);
		s1_next.working    = working_next;
		s1_next.d0         = win_digit[1];
		s1_next.d1         = win_digit[2];
		s1_next.d3         = win_digit[4];
		s1_next.d4         = win_digit[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_next;
		end
	end

	arp_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (s2_load),
		.s1             (s1_s1),
		.distance_cm    (distance_cm),
		.new_distance   (new_distance),
		.sensor_working (sensor_working)
	);

	assign m_axis_tvalid = s2_valid_q;
	assign m_axis_tdata  = {6'd0, sensor_working, new_distance, distance_cm};

endmodule
